@@ rtl/l_statistic_accumulator_assert.svh @@
// ============================================================================
// Assertion macros for the L statistic accumulator
// Short forms for same-cycle and next-cycle checks, clocked on the rising
// edge and disabled while reset is asserted.
// ============================================================================
`ifndef L_STATISTIC_ACCUMULATOR_ASSERT_SVH
`define L_STATISTIC_ACCUMULATOR_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define LSA_ASSERT_NOW(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("l_statistic_accumulator: same-cycle check failed");

// The consequent must hold in the cycle after the antecedent.
`define LSA_ASSERT_NEXT(label, clk, rstn, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
    else $error("l_statistic_accumulator: next-cycle check failed");

`endif

@@ rtl/lsa_pkg.sv @@
// ============================================================================
// L statistic accumulator package
// Widths, constants and the queue entry type shared by all modules.
// ============================================================================
package lsa_pkg;

  // Input and output field widths.
  localparam int unsigned INT_W = 32;
  localparam int unsigned SEL_W = 5;
  localparam int unsigned CNT_W = 32;
  localparam int unsigned SUM_W = 48;

  // Magnitudes of a-b and a+b need 33 bits; the divider remainder one more.
  localparam int unsigned MAG_W = INT_W + 1;
  localparam int unsigned REM_W = MAG_W + 1;

  // Quotient |L| in Q.16 is at most 1.0, so 17 bits.
  localparam int unsigned Q_BITS = 17;
  localparam int unsigned STEP_W = 5;
  localparam logic [Q_BITS-1:0] Q16_ONE = 17'h10000;

  // Square of |L| in Q.16 after dropping 16 fraction bits.
  localparam int unsigned SQ_W = 2 * Q_BITS - 16;

  // One classified pair as it waits between the front and back ends.
  typedef struct packed {
    logic             ok;
    logic [MAG_W-1:0] num;
    logic [MAG_W-1:0] den;
    logic [SEL_W-1:0] read_bin;
  } pair_t;

endpackage

@@ rtl/lsa_if.sv @@
// ============================================================================
// L statistic accumulator channels
// Valid/ready channels for input pairs and for results.
// ============================================================================
interface lsa_in_if;
  logic                             valid;
  logic                             ready;
  logic signed [lsa_pkg::INT_W-1:0] intensity_first;
  logic signed [lsa_pkg::INT_W-1:0] intensity_second;
  logic        [lsa_pkg::SEL_W-1:0] read_bin;

  modport source (output valid, intensity_first, intensity_second, read_bin, input ready);
  modport sink   (input valid, intensity_first, intensity_second, read_bin, output ready);
endinterface

interface lsa_out_if;
  logic                      valid;
  logic                      ready;
  logic                      accepted;
  logic [lsa_pkg::SEL_W-1:0] bin_index;
  logic [lsa_pkg::CNT_W-1:0] pair_count;
  logic [lsa_pkg::SUM_W-1:0] sum_abs_l;
  logic [lsa_pkg::SUM_W-1:0] sum_l_squared;
  logic [lsa_pkg::CNT_W-1:0] bin_count;

  modport source (output valid, accepted, bin_index, pair_count, sum_abs_l, sum_l_squared,
                  bin_count, input ready);
  modport sink   (input valid, accepted, bin_index, pair_count, sum_abs_l, sum_l_squared,
                  bin_count, output ready);
endinterface

@@ rtl/l_statistic_accumulator.sv @@
// A counted pair goes from pop through 17 divider steps, the done pulse, multiply and
// commit; a rejected pair goes from pop straight to commit. Commit waits while the result
// register is full. The back end takes a new pair only after the last one is committed,
// as the one shared divider serves every counted pair. Two pairs may queue ahead of it.
// Reset (rst_ni low, asynchronous) clears all counters, sums and the queue at once.
// ============================================================================
// L statistic accumulator
// Accumulates |L| and L^2 sums, the pair count and a cumulative histogram
// of |L| over pairs of neighboring intensities.
// ============================================================================
module l_statistic_accumulator #(
  parameter int unsigned NBINS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsa_in_if.sink      in_i,
  lsa_out_if.source   out_o
);

  logic           push;
  logic           pop;
  logic           full;
  logic           empty;
  lsa_pkg::pair_t entry;
  lsa_pkg::pair_t head;

  // Classification of incoming pairs.
  lsa_front u_front (
    .in_i    (in_i),
    .full_i  (full),
    .push_o  (push),
    .entry_o (entry)
  );

  // Queue between the front and back ends.
  lsa_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .entry_i (entry),
    .pop_i   (pop),
    .full_o  (full),
    .empty_o (empty),
    .head_o  (head)
  );

  // Division, statistics update and result register.
  lsa_back #(
    .NBINS (NBINS)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .empty_i (empty),
    .head_i  (head),
    .pop_o   (pop),
    .out_o   (out_o)
  );

endmodule

@@ rtl/lsa_front.sv @@
// ============================================================================
// L statistic accumulator front end
// Accepts pairs, forms |a-b| and |a+b| and decides whether the pair counts.
// ============================================================================
module lsa_front (
  lsa_in_if.sink          in_i,
  input  logic            full_i,
  output logic            push_o,
  output lsa_pkg::pair_t  entry_o
);

  logic signed [lsa_pkg::MAG_W:0]   a_ext;
  logic signed [lsa_pkg::MAG_W:0]   b_ext;
  logic signed [lsa_pkg::MAG_W:0]   diff;
  logic signed [lsa_pkg::MAG_W:0]   sum;
  logic        [lsa_pkg::MAG_W-1:0] num;
  logic        [lsa_pkg::MAG_W-1:0] den;

  // The input is ready whenever the queue has room; a valid pair then transfers.
  assign in_i.ready = !full_i;
  assign push_o     = in_i.valid && in_i.ready;

  // Exact difference and sum in a widened signed range.
  assign a_ext = (lsa_pkg::MAG_W + 1)'(in_i.intensity_first);
  assign b_ext = (lsa_pkg::MAG_W + 1)'(in_i.intensity_second);
  assign diff  = a_ext - b_ext;
  assign sum   = a_ext + b_ext;
  assign num   = diff[lsa_pkg::MAG_W] ? lsa_pkg::MAG_W'(-diff) : lsa_pkg::MAG_W'(diff);
  assign den   = sum[lsa_pkg::MAG_W]  ? lsa_pkg::MAG_W'(-sum)  : lsa_pkg::MAG_W'(sum);

  // A pair counts when neither intensity is zero, the sum is not zero and |L| <= 1.
  always_comb begin
    entry_o.ok       = (in_i.intensity_first != '0) && (in_i.intensity_second != '0) &&
                       (sum != '0) && (num <= den);
    entry_o.num      = num;
    entry_o.den      = den;
    entry_o.read_bin = in_i.read_bin;
  end

endmodule

@@ rtl/lsa_fifo.sv @@
// ============================================================================
// L statistic accumulator pair queue
// Two-entry queue that decouples the front end from the back end.
// ============================================================================
module lsa_fifo (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  lsa_pkg::pair_t  entry_i,
  input  logic            pop_i,
  output logic            full_o,
  output logic            empty_o,
  output lsa_pkg::pair_t  head_o
);

  lsa_pkg::pair_t mem_q [2];
  logic           wr_ptr_q;
  logic           rd_ptr_q;
  logic [1:0]     count_q;

  assign full_o  = count_q == 2'd2;
  assign empty_o = count_q == 2'd0;
  assign head_o  = mem_q[rd_ptr_q];

  // Pointers and fill level.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= 1'b0;
      rd_ptr_q <= 1'b0;
      count_q  <= 2'd0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= !wr_ptr_q;
      end
      if (pop_i) begin
        rd_ptr_q <= !rd_ptr_q;
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + 2'd1;
      end else if (pop_i && !push_i) begin
        count_q <= count_q - 2'd1;
      end
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= entry_i;
    end
  end

endmodule

@@ rtl/lsa_divider.sv @@
// ============================================================================
// L statistic accumulator divider
// Restoring radix-2 divider forming (num << 16) / den, one bit per cycle,
// for num <= den, so the quotient fits 17 bits.
// ============================================================================
module lsa_divider (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       start_i,
  input  logic [lsa_pkg::MAG_W-1:0]  num_i,
  input  logic [lsa_pkg::MAG_W-1:0]  den_i,
  output logic                       done_o,
  output logic [lsa_pkg::Q_BITS-1:0] quotient_o
);

  localparam logic [lsa_pkg::STEP_W-1:0] LastStep = lsa_pkg::STEP_W'(lsa_pkg::Q_BITS - 1);

  logic                        busy_q;
  logic                        done_q;
  logic [lsa_pkg::STEP_W-1:0]  step_q;
  logic [lsa_pkg::REM_W-1:0]   rem_q;
  logic [lsa_pkg::MAG_W-1:0]   den_q;
  logic [lsa_pkg::Q_BITS-1:0]  quo_q;
  logic                        q_bit;
  logic [lsa_pkg::REM_W-1:0]   rem_sub;

  // Trial subtraction of the divisor from the partial remainder.
  assign q_bit   = rem_q >= {1'b0, den_q};
  assign rem_sub = q_bit ? rem_q - {1'b0, den_q} : rem_q;

  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // Step sequencing.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      step_q <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        step_q <= '0;
      end else if (busy_q) begin
        step_q <= step_q + 1'b1;
        if (step_q == LastStep) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  // Remainder and quotient shift registers.
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q <= {1'b0, num_i};
      den_q <= den_i;
      quo_q <= '0;
    end else if (busy_q) begin
      rem_q <= {rem_sub[lsa_pkg::REM_W-2:0], 1'b0};
      quo_q <= {quo_q[lsa_pkg::Q_BITS-2:0], q_bit};
    end
  end

endmodule

@@ rtl/lsa_back.sv @@
// ============================================================================
// L statistic accumulator back end
// Takes classified pairs from the queue, divides, squares, bins, updates the
// sums and the cumulative histogram, and registers the result.
// ============================================================================
`include "l_statistic_accumulator_assert.svh"

module lsa_back #(
  parameter int unsigned NBINS = 20
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            empty_i,
  input  lsa_pkg::pair_t  head_i,
  output logic            pop_o,
  lsa_out_if.source       out_o
);

  localparam int unsigned BW = $clog2(NBINS + 1);
  localparam logic [lsa_pkg::CNT_W-1:0] CntMax = '1;
  localparam logic [lsa_pkg::SUM_W-1:0] SumMax = '1;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_DIV  = 4'b0010,
    S_MUL  = 4'b0100,
    S_OUT  = 4'b1000
  } state_e;

  state_e                       state_q;
  state_e                       state_d;
  logic                         start;
  logic                         div_done;
  logic [lsa_pkg::Q_BITS-1:0]   quotient;
  logic                         out_free;
  logic                         commit;

  logic                         ok_q;
  logic [BW-1:0]                bin_q;
  logic [lsa_pkg::Q_BITS-1:0]   q_q;
  logic [lsa_pkg::SQ_W-1:0]     sq_q;
  logic [lsa_pkg::SEL_W-1:0]    sel_q;

  logic [2*lsa_pkg::Q_BITS-1:0] sq_full;
  logic [lsa_pkg::Q_BITS+7:0]   bin_full;

  logic [lsa_pkg::CNT_W-1:0]    pairs_q;
  logic [lsa_pkg::CNT_W-1:0]    pairs_d;
  logic [lsa_pkg::SUM_W-1:0]    abs_q;
  logic [lsa_pkg::SUM_W-1:0]    abs_d;
  logic [lsa_pkg::SUM_W-1:0]    sqs_q;
  logic [lsa_pkg::SUM_W-1:0]    sqs_d;
  logic [lsa_pkg::SUM_W:0]      abs_sum;
  logic [lsa_pkg::SUM_W:0]      sqs_sum;
  logic [lsa_pkg::CNT_W-1:0]    cnt_q [NBINS+1];
  logic [lsa_pkg::CNT_W-1:0]    cnt_d [NBINS+1];
  logic [lsa_pkg::CNT_W-1:0]    bin_count;

  logic                         out_valid_q;
  logic                         out_ok_q;
  logic [lsa_pkg::SEL_W-1:0]    out_bin_q;
  logic [lsa_pkg::CNT_W-1:0]    out_pairs_q;
  logic [lsa_pkg::SUM_W-1:0]    out_abs_q;
  logic [lsa_pkg::SUM_W-1:0]    out_sqs_q;
  logic [lsa_pkg::CNT_W-1:0]    out_cnt_q;

  // Queue head is taken only when the sequencer is idle.
  assign pop_o  = (state_q == S_IDLE) && !empty_i;
  assign start  = pop_o && head_i.ok;

  lsa_divider u_divider (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (start),
    .num_i      (head_i.num),
    .den_i      (head_i.den),
    .done_o     (div_done),
    .quotient_o (quotient)
  );

  // The result register is free when empty or being drained this cycle.
  assign out_free = !out_valid_q || out_o.ready;
  assign commit   = (state_q == S_OUT) && out_free;

  // Sequencer.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          state_d = head_i.ok ? S_DIV : S_OUT;
        end
      end
      S_DIV: begin
        if (div_done) begin
          state_d = S_MUL;
        end
      end
      S_MUL: begin
        state_d = S_OUT;
      end
      S_OUT: begin
        if (out_free) begin
          state_d = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // Square and bin of the quotient.
  assign sq_full  = quotient * quotient;
  assign bin_full = (lsa_pkg::Q_BITS + 8)'(quotient) * (lsa_pkg::Q_BITS + 8)'(NBINS);

  // Per-pair working registers.
  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      sel_q <= head_i.read_bin;
      ok_q  <= head_i.ok;
      bin_q <= '0;
      q_q   <= '0;
      sq_q  <= '0;
    end else if (state_q == S_MUL) begin
      q_q   <= quotient;
      sq_q  <= sq_full[2*lsa_pkg::Q_BITS-1:16];
      bin_q <= BW'(bin_full[lsa_pkg::Q_BITS+7:16]);
    end
  end

  // Saturating totals.
  assign abs_sum = {1'b0, abs_q} + (lsa_pkg::SUM_W + 1)'(q_q);
  assign sqs_sum = {1'b0, sqs_q} + (lsa_pkg::SUM_W + 1)'(sq_q);

  always_comb begin
    pairs_d = pairs_q;
    abs_d   = abs_q;
    sqs_d   = sqs_q;
    if (ok_q) begin
      pairs_d = (pairs_q == CntMax) ? pairs_q : pairs_q + 1'b1;
      abs_d   = abs_sum[lsa_pkg::SUM_W] ? SumMax : abs_sum[lsa_pkg::SUM_W-1:0];
      sqs_d   = sqs_sum[lsa_pkg::SUM_W] ? SumMax : sqs_sum[lsa_pkg::SUM_W-1:0];
    end
  end

  // Cumulative histogram: every counter at or above the pair's bin steps up.
  always_comb begin
    for (int k = 0; k <= NBINS; k++) begin
      cnt_d[k] = cnt_q[k];
      if (ok_q && (BW'(k) >= bin_q) && (cnt_q[k] != CntMax)) begin
        cnt_d[k] = cnt_q[k] + 1'b1;
      end
    end
  end

  // Selected counter after the update; indexes above the top bin read zero.
  assign bin_count = (32'(sel_q) <= NBINS) ? cnt_d[BW'(sel_q)] : '0;

  // Control and statistics state.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
      pairs_q     <= '0;
      abs_q       <= '0;
      sqs_q       <= '0;
      for (int k = 0; k <= NBINS; k++) begin
        cnt_q[k] <= '0;
      end
    end else begin
      state_q <= state_d;
      if (commit) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
      if (commit) begin
        pairs_q <= pairs_d;
        abs_q   <= abs_d;
        sqs_q   <= sqs_d;
        for (int k = 0; k <= NBINS; k++) begin
          cnt_q[k] <= cnt_d[k];
        end
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (commit) begin
      out_ok_q    <= ok_q;
      out_bin_q   <= lsa_pkg::SEL_W'(bin_q);
      out_pairs_q <= pairs_d;
      out_abs_q   <= abs_d;
      out_sqs_q   <= sqs_d;
      out_cnt_q   <= bin_count;
    end
  end

  assign out_o.valid         = out_valid_q;
  assign out_o.accepted      = out_ok_q;
  assign out_o.bin_index     = out_bin_q;
  assign out_o.pair_count    = out_pairs_q;
  assign out_o.sum_abs_l     = out_abs_q;
  assign out_o.sum_l_squared = out_sqs_q;
  assign out_o.bin_count     = out_cnt_q;

  // Checks on the sequencer, the divider and the histogram.
  `LSA_ASSERT_NOW(a_done_in_div, clk_i, rst_ni, div_done, state_q == S_DIV)
  `LSA_ASSERT_NOW(a_quotient_max, clk_i, rst_ni, div_done, quotient <= lsa_pkg::Q16_ONE)
  `LSA_ASSERT_NEXT(a_div_to_mul, clk_i, rst_ni, (state_q == S_DIV) && div_done, state_q == S_MUL)
  `LSA_ASSERT_NOW(a_top_bin_total, clk_i, rst_ni, 1'b1, cnt_q[NBINS] == pairs_q)
  `LSA_ASSERT_NOW(a_cumulative, clk_i, rst_ni, 1'b1, cnt_q[0] <= cnt_q[NBINS])

endmodule

@@ tb/lsa_stat_checker.sv @@
// ============================================================================
// L statistic accumulator result checker
// Watches both channels. For every pair the block takes in, it computes the
// expected totals and histogram counter. For every result it reads out, it
// compares each field with the oldest expected result.
// ============================================================================
module lsa_stat_checker #(
  parameter int unsigned NBINS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  lsa_in_if           in_mon,
  lsa_out_if          out_mon,
  output int unsigned fail_count_o,
  output int unsigned pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [63:0] CNT_MAX = (64'd1 << lsa_pkg::CNT_W) - 64'd1;
  localparam logic [63:0] SUM_MAX = (64'd1 << lsa_pkg::SUM_W) - 64'd1;
  localparam logic [63:0] L_ONE   = 64'd1 << 16;

  typedef struct packed {
    logic                      accepted;
    logic [lsa_pkg::SEL_W-1:0] bin_index;
    logic [lsa_pkg::CNT_W-1:0] pair_count;
    logic [lsa_pkg::SUM_W-1:0] sum_abs_l;
    logic [lsa_pkg::SUM_W-1:0] sum_l_squared;
    logic [lsa_pkg::CNT_W-1:0] bin_count;
  } stat_result_t;

  // Local copy of the accumulator state.
  logic [lsa_pkg::CNT_W-1:0] cum_hist [0:NBINS];
  logic [lsa_pkg::CNT_W-1:0] pair_total;
  logic [lsa_pkg::SUM_W-1:0] abs_l_sum;
  logic [lsa_pkg::SUM_W-1:0] l_sq_sum;

  stat_result_t expected_stats [$];
  stat_result_t oldest_stat;

  function automatic logic [63:0] add_sat(logic [63:0] acc, logic [63:0] inc,
                                          logic [63:0] limit);
    logic [63:0] total;
    total = acc + inc;
    return (total > limit) ? limit : total;
  endfunction

  // Classifies one pair, updates the local state and returns the result
  // the block must produce for it.
  function automatic stat_result_t accumulate_pair(
      logic signed [lsa_pkg::INT_W-1:0] first,
      logic signed [lsa_pkg::INT_W-1:0] second,
      logic [lsa_pkg::SEL_W-1:0] sel);
    logic signed [63:0] a_ext;
    logic signed [63:0] b_ext;
    logic signed [63:0] diff;
    logic signed [63:0] total;
    logic [63:0]        num;
    logic [63:0]        den;
    logic [63:0]        quot;
    logic [63:0]        quot_sq;
    logic [63:0]        bin;
    stat_result_t       res;
    a_ext = first;
    b_ext = second;
    diff  = a_ext - b_ext;
    total = a_ext + b_ext;
    res   = '0;
    if (a_ext != 0 && b_ext != 0 && total != 0) begin
      num = (diff < 0) ? -diff : diff;
      den = (total < 0) ? -total : total;
      // The exact magnitude comparison decides rejection, not the quotient.
      if (num <= den) begin
        quot    = (num << 16) / den;
        quot_sq = (quot * quot) >> 16;
        if (quot > L_ONE) begin
          quot = L_ONE;
        end
        bin = (quot * NBINS) >> 16;
        if (bin > NBINS) begin
          bin = NBINS;
        end
        abs_l_sum  = lsa_pkg::SUM_W'(add_sat(abs_l_sum, quot, SUM_MAX));
        l_sq_sum   = lsa_pkg::SUM_W'(add_sat(l_sq_sum, quot_sq, SUM_MAX));
        pair_total = lsa_pkg::CNT_W'(add_sat(pair_total, 64'd1, CNT_MAX));
        // Cumulative histogram: every bin from this one upward counts the pair.
        for (int k = int'(bin); k <= int'(NBINS); k++) begin
          cum_hist[k] = lsa_pkg::CNT_W'(add_sat(cum_hist[k], 64'd1, CNT_MAX));
        end
        res.accepted  = 1'b1;
        res.bin_index = bin[lsa_pkg::SEL_W-1:0];
      end
    end
    res.pair_count    = pair_total;
    res.sum_abs_l     = abs_l_sum;
    res.sum_l_squared = l_sq_sum;
    res.bin_count     = (sel <= NBINS) ? cum_hist[sel] : '0;
    return res;
  endfunction

  function automatic void check_field(string name, logic [63:0] exp_val,
                                      logic [63:0] act_val);
    if (act_val !== exp_val) begin
      $error("%s: expected %0d, actual %0d", name, exp_val, act_val);
      fail_count_o++;
    end
  endfunction

  // Track transfers on both channels and compare results in order.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int k = 0; k <= int'(NBINS); k++) begin
        cum_hist[k] = '0;
      end
      pair_total   = '0;
      abs_l_sum    = '0;
      l_sq_sum     = '0;
      expected_stats.delete();
      fail_count_o = 0;
      pending_o   <= 0;
    end else begin
      if (out_mon.valid && out_mon.ready) begin
        if (expected_stats.size() == 0) begin
          $error("result transfer with no pair outstanding");
          fail_count_o++;
        end else begin
          oldest_stat = expected_stats.pop_front();
          check_field("accepted", 64'(oldest_stat.accepted), 64'(out_mon.accepted));
          check_field("bin_index", 64'(oldest_stat.bin_index), 64'(out_mon.bin_index));
          check_field("pair_count", 64'(oldest_stat.pair_count), 64'(out_mon.pair_count));
          check_field("sum_abs_l", 64'(oldest_stat.sum_abs_l), 64'(out_mon.sum_abs_l));
          check_field("sum_l_squared", 64'(oldest_stat.sum_l_squared),
                      64'(out_mon.sum_l_squared));
          check_field("bin_count", 64'(oldest_stat.bin_count), 64'(out_mon.bin_count));
        end
      end
      if (in_mon.valid && in_mon.ready) begin
        expected_stats.insert(expected_stats.size(),
                              accumulate_pair(in_mon.intensity_first,
                                              in_mon.intensity_second,
                                              in_mon.read_bin));
      end
      pending_o <= unsigned'(expected_stats.size());
    end
  end

endmodule

@@ tb/tb.sv @@
// ============================================================================
// L statistic accumulator testbench
// Sends directed and random intensity pairs through the block under varying
// sender and receiver idling, a long receiver hold-off and drain pauses, and
// reports the verdict of the result checker.
// ============================================================================
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned NBINS          = 20;
  localparam int          HALF_PERIOD    = 10;
  localparam int          LONG_HOLD      = 300;
  localparam int          WATCHDOG_LIMIT = 2000;
  localparam int          DRAIN_CYCLES   = 40;

  logic clk_i  = 1'b0;
  logic rst_ni = 1'b0;

  int unsigned tx_idle_pct    = 35;
  int unsigned rx_idle_pct    = 76;
  logic        long_hold_req  = 1'b0;
  logic        long_hold_done = 1'b0;
  int unsigned mismatch_count;
  int unsigned results_pending;
  int unsigned quiet_cycles   = 0;

  always #(HALF_PERIOD) clk_i = ~clk_i;

  lsa_in_if  in_if ();
  lsa_out_if out_if ();

  l_statistic_accumulator #(
    .NBINS (NBINS)
  ) i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  lsa_stat_checker #(
    .NBINS (NBINS)
  ) i_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_mon       (in_if),
    .out_mon      (out_if),
    .fail_count_o (mismatch_count),
    .pending_o    (results_pending)
  );

  // Result receiver: random backpressure, or one long hold-off on request.
  initial begin
    out_if.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (long_hold_req && !long_hold_done) begin
        out_if.ready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk_i);
        long_hold_done = 1'b1;
      end
      out_if.ready <= ($urandom_range(99) >= rx_idle_pct);
    end
  end

  // Watchdog: too long without any transfer means the block has hung.
  always @(posedge clk_i) begin
    if (!rst_ni || (in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("end of test: mismatches");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // Offer one pair, with random idle cycles first, and wait for its transfer.
  task automatic send_pair(logic signed [lsa_pkg::INT_W-1:0] first,
                           logic signed [lsa_pkg::INT_W-1:0] second,
                           logic [lsa_pkg::SEL_W-1:0] sel);
    while ($urandom_range(99) < tx_idle_pct) begin
      in_if.valid <= 1'b0;
      @(posedge clk_i);
    end
    in_if.valid            <= 1'b1;
    in_if.intensity_first  <= first;
    in_if.intensity_second <= second;
    in_if.read_bin         <= sel;
    do @(posedge clk_i); while (!in_if.ready);
  endtask

  // Mostly same-sign pairs, which are counted; the rest exercise each way
  // a pair can be rejected.
  task automatic send_random_pairs(int unsigned count);
    int unsigned                      kind;
    logic [lsa_pkg::INT_W-1:0]        mask;
    logic [lsa_pkg::INT_W-1:0]        mag_a;
    logic [lsa_pkg::INT_W-1:0]        mag_b;
    logic                             neg;
    logic signed [lsa_pkg::INT_W-1:0] first;
    logic signed [lsa_pkg::INT_W-1:0] second;
    logic [lsa_pkg::SEL_W-1:0]        sel;
    repeat (count) begin
      kind  = $urandom_range(99);
      mask  = 32'hFFFF_FFFF >> (32 - $urandom_range(31, 1));
      mag_a = $urandom & mask;
      if ($urandom_range(3) == 0) begin
        mask = 32'hFFFF_FFFF >> (32 - $urandom_range(31, 1));
      end
      mag_b = $urandom & mask;
      if (mag_a == 0) mag_a = 1;
      if (mag_b == 0) mag_b = 1;
      neg = 1'($urandom_range(1));
      if (kind < 70) begin
        first  = neg ? -mag_a : mag_a;
        second = neg ? -mag_b : mag_b;
      end else if (kind < 85) begin
        // Opposite signs always give |L| above one.
        first  = neg ? -mag_a : mag_a;
        second = neg ? mag_b : -mag_b;
      end else if (kind < 91) begin
        first  = $urandom_range(1) ? 32'd0 : $urandom;
        second = (first == 0) ? $urandom : 32'd0;
      end else if (kind < 96) begin
        first  = $urandom;
        second = -first;
      end else begin
        first  = $urandom;
        second = $urandom;
      end
      sel = ($urandom_range(9) == 0) ? lsa_pkg::SEL_W'($urandom_range(31, NBINS + 1))
                                     : lsa_pkg::SEL_W'($urandom_range(NBINS, 0));
      send_pair(first, second, sel);
    end
  endtask

  // Stop offering and wait until every outstanding result has come back.
  task automatic wait_results_drained();
    in_if.valid <= 1'b0;
    @(posedge clk_i);
    while (results_pending != 0) @(posedge clk_i);
  endtask

  // Stimulus and verdict.
  initial begin
    in_if.valid            <= 1'b0;
    in_if.intensity_first  <= '0;
    in_if.intensity_second <= '0;
    in_if.read_bin         <= '0;
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed pairs: extremes, each rejection and exact bin boundaries.
    send_pair(32'sd1, 32'sd1, 5'd0);
    send_pair(-32'sd1, -32'sd1, 5'(NBINS));
    send_pair(32'sd0, 32'sd5, 5'd3);
    send_pair(32'sd7, 32'sd0, 5'd4);
    send_pair(32'sd0, 32'sd0, 5'd5);
    send_pair(32'sd5, -32'sd5, 5'd6);
    send_pair(-32'sd1, 32'sd1, 5'd7);
    send_pair(32'sd5, -32'sd3, 5'd8);
    send_pair(32'h8000_0000, 32'h7FFF_FFFF, 5'd9);
    send_pair(32'h8000_0000, 32'h8000_0000, 5'd20);
    send_pair(32'h7FFF_FFFF, 32'h7FFF_FFFF, 5'd21);
    send_pair(32'sd1, 32'h7FFF_FFFF, 5'd31);
    send_pair(32'h8000_0000, -32'sd1, 5'd19);
    send_pair(32'sd3, 32'sd1, 5'd10);
    send_pair(32'sd1, 32'sd3, 5'd10);
    send_pair(32'sd19, 32'sd1, 5'd18);
    send_pair(32'sd21, 32'sd19, 5'd1);
    send_pair(-32'sd2147483647, 32'sd1, 5'd15);
    send_pair(32'h7FFF_FFFF, 32'sd1, 5'd19);
    send_pair(32'sd1, 32'sd2, 5'd6);
    send_pair(32'sd100, 32'sd99, 5'd2);
    send_pair(-32'sd12, -32'sd4, 5'd0);

    send_random_pairs(170);

    // Let everything drain, then fill the block against a held-off receiver.
    wait_results_drained();
    tx_idle_pct   = 0;
    long_hold_req = 1'b1;
    send_random_pairs(24);

    tx_idle_pct = 76;
    rx_idle_pct = 35;
    send_random_pairs(150);
    wait_results_drained();

    tx_idle_pct = 0;
    rx_idle_pct = 0;
    send_random_pairs(150);

    wait_results_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatch_count == 0 && results_pending == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/lsa_pkg.sv
rtl/lsa_if.sv
rtl/lsa_front.sv
rtl/lsa_fifo.sv
rtl/lsa_divider.sv
rtl/lsa_back.sv
rtl/l_statistic_accumulator.sv
tb/lsa_stat_checker.sv
tb/tb.sv
